### design/ftle_pkg.sv
// ----------------------------------------------------------------------------
// ftle_pkg: shared constants and types for the FTLE pipeline
// Word formats, step counts of the iterative units and pipeline depth.
// ----------------------------------------------------------------------------
`default_nettype none

package ftle_pkg;

    // Fixed-point word format
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int MAG_BITS  = WORD_BITS;
    localparam int POS_BITS  = WORD_BITS - 1;

    // Divider: magnitude shifted up by the fraction, one quotient bit per step
    localparam int NUM_BITS  = MAG_BITS + FRAC_BITS;
    localparam int DIV_STEPS = NUM_BITS;
    localparam int LANES     = 4;

    // Products and their shifted sums
    localparam int PROD_BITS = 2 * MAG_BITS;
    localparam int SH_BITS   = PROD_BITS - FRAC_BITS + 1;

    // Square root: one root bit per step
    localparam int ROOT_BITS = WORD_BITS;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS  = ROOT_BITS + 2;

    // Log unit
    localparam int LOG_FRAC   = 30;
    localparam int LOG_M_BITS = LOG_FRAC + 1;
    localparam int K_BITS     = $clog2(POS_BITS);
    localparam int LG_BITS    = K_BITS + 1 + LOG_FRAC;
    localparam int LN2_BITS   = 27;
    localparam int LN2_Q26    = 46516320;
    localparam int LN_SHIFT   = 56 - FRAC_BITS;
    localparam int V_BITS     = LG_BITS + LN2_BITS;
    localparam longint NEAR_ZERO_RAW = (longint'(1) << FRAC_BITS) / 1000000000;

    localparam logic signed [V_BITS-1:0] ROUND_HALF = V_BITS'(1) <<< (LN_SHIFT - 1);

    // Lane codes
    localparam int LANE_A11 = 0;
    localparam int LANE_A21 = 1;
    localparam int LANE_A12 = 2;
    localparam int LANE_A22 = 3;

    // Entry, divider, six arithmetic stages, root, two log-prep stages, log, scale
    localparam int PIPE_DEPTH = 1 + DIV_STEPS + 6 + ROOT_BITS + 2 + LOG_FRAC + 1;

    typedef logic [MAG_BITS-1:0] mag_t;

    localparam mag_t POS_MAX = {1'b0, {(MAG_BITS-1){1'b1}}};
    localparam mag_t NEG_LIM = {1'b1, {(MAG_BITS-1){1'b0}}};

    typedef struct packed {
        logic neg;
        mag_t mag;
    } sm_t;

    typedef struct packed {
        logic valid;
        logic in_dom;
        logic sat;
    } ctl_t;

    typedef struct packed {
        logic             lr;
        logic             tb;
        logic             dz_x;
        logic             dz_y;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] nz;
    } side_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] ftle_value;
        logic                 computed;
        logic                 saturated;
    } out_item_t;

endpackage

`default_nettype wire

### design/ftle_if.sv
// ----------------------------------------------------------------------------
// ftle_if: valid/ready channels of the FTLE pipeline
// Input channel carries one particle, output channel one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftle_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 inside_req;
    logic                                 lr_valid;
    logic                                 tb_valid;
    logic signed [ftle_pkg::WORD_BITS-1:0] dx_lr;
    logic signed [ftle_pkg::WORD_BITS-1:0] dy_lr;
    logic signed [ftle_pkg::WORD_BITS-1:0] span_x;
    logic signed [ftle_pkg::WORD_BITS-1:0] dx_tb;
    logic signed [ftle_pkg::WORD_BITS-1:0] dy_tb;
    logic signed [ftle_pkg::WORD_BITS-1:0] span_y;

    modport source (
        output valid, inside_req, lr_valid, tb_valid,
        output dx_lr, dy_lr, span_x, dx_tb, dy_tb, span_y,
        input  ready
    );
    modport sink (
        input  valid, inside_req, lr_valid, tb_valid,
        input  dx_lr, dy_lr, span_x, dx_tb, dy_tb, span_y,
        output ready
    );
endinterface

interface ftle_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ftle_pkg::WORD_BITS-1:0] ftle_value;
    logic                                 computed;
    logic                                 saturated;

    modport source (output valid, ftle_value, computed, saturated, input ready);
    modport sink   (input valid, ftle_value, computed, saturated, output ready);
endinterface

`default_nettype wire

### design/ftle_div.sv
// ----------------------------------------------------------------------------
// ftle_div: pipelined restoring divider lane
// Unsigned (num << FRAC_BITS) / den, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ftle_div (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire ftle_pkg::mag_t                num_mag,
    input  wire ftle_pkg::mag_t                den_mag,
    output logic [ftle_pkg::NUM_BITS-1:0]      quo
);

    ftle_pkg::mag_t                 rem_reg [0:ftle_pkg::DIV_STEPS-1];
    logic [ftle_pkg::NUM_BITS-1:0]  nq_reg  [0:ftle_pkg::DIV_STEPS-1];
    ftle_pkg::mag_t                 den_reg [0:ftle_pkg::DIV_STEPS-2];

    for (genvar j = 0; j < ftle_pkg::DIV_STEPS; j++) begin : g_step
        ftle_pkg::mag_t                rem_prev;
        ftle_pkg::mag_t                den_prev;
        logic [ftle_pkg::NUM_BITS-1:0] nq_prev;
        logic [ftle_pkg::MAG_BITS:0]   rem_sh;
        logic [ftle_pkg::MAG_BITS:0]   rem_next;
        logic                          take;

        // Select the previous stage, or the operands at the head
        if (j == 0) begin : g_head
            assign rem_prev = '0;
            assign nq_prev  = {num_mag, {ftle_pkg::FRAC_BITS{1'b0}}};
            assign den_prev = den_mag;
        end else begin : g_body
            assign rem_prev = rem_reg[j-1];
            assign nq_prev  = nq_reg[j-1];
            assign den_prev = den_reg[j-1];
        end

        // Shift in one dividend bit, subtract when it fits
        assign rem_sh   = {rem_prev, nq_prev[ftle_pkg::NUM_BITS-1]};
        assign take     = rem_sh >= {1'b0, den_prev};
        assign rem_next = take ? (rem_sh - {1'b0, den_prev}) : rem_sh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next[ftle_pkg::MAG_BITS-1:0];
                nq_reg[j]  <= {nq_prev[ftle_pkg::NUM_BITS-2:0], take};
            end
        end

        if (j < ftle_pkg::DIV_STEPS - 1) begin : g_den
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[j] <= den_prev;
                end
            end
        end
    end

    assign quo = nq_reg[ftle_pkg::DIV_STEPS-1];

endmodule

`default_nettype wire

### design/ftle_sqrt.sv
// ----------------------------------------------------------------------------
// ftle_sqrt: pipelined integer square root
// Floor root of a wide radicand, one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ftle_sqrt (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [ftle_pkg::RAD_BITS-1:0] rad,
    output logic [ftle_pkg::ROOT_BITS-1:0]     root
);

    logic [ftle_pkg::REM_BITS-1:0]  rem_reg  [0:ftle_pkg::ROOT_BITS-1];
    logic [ftle_pkg::ROOT_BITS-1:0] root_reg [0:ftle_pkg::ROOT_BITS-1];
    logic [ftle_pkg::RAD_BITS-1:0]  rad_reg  [0:ftle_pkg::ROOT_BITS-2];

    for (genvar j = 0; j < ftle_pkg::ROOT_BITS; j++) begin : g_step
        logic [ftle_pkg::REM_BITS-1:0]  rem_prev;
        logic [ftle_pkg::ROOT_BITS-1:0] root_prev;
        logic [ftle_pkg::RAD_BITS-1:0]  rad_prev;
        logic [ftle_pkg::REM_BITS+1:0]  rem_sh;
        logic [ftle_pkg::REM_BITS+1:0]  trial;
        logic [ftle_pkg::REM_BITS+1:0]  rem_next;
        logic                           take;

        if (j == 0) begin : g_head
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = rad;
        end else begin : g_body
            assign rem_prev  = rem_reg[j-1];
            assign root_prev = root_reg[j-1];
            assign rad_prev  = rad_reg[j-1];
        end

        // Bring down two radicand bits, try root*4+1
        assign rem_sh   = {rem_prev, rad_prev[ftle_pkg::RAD_BITS-1 -: 2]};
        assign trial    = (ftle_pkg::REM_BITS + 2)'({root_prev, 2'b01});
        assign take     = rem_sh >= trial;
        assign rem_next = take ? (rem_sh - trial) : rem_sh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next[ftle_pkg::REM_BITS-1:0];
                root_reg[j] <= {root_prev[ftle_pkg::ROOT_BITS-2:0], take};
            end
        end

        if (j < ftle_pkg::ROOT_BITS - 1) begin : g_rad
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[j] <= rad_prev << 2;
                end
            end
        end
    end

    assign root = root_reg[ftle_pkg::ROOT_BITS-1];

endmodule

`default_nettype wire

### design/ftle_from_neighbor_displacement.sv
// Items pass the entry, divider, arithmetic, root, log-prep, log and scale stages.
// Throughput: one item per cycle unless stalled; the 48-step divider lanes,
// the 32-step root and the 30 squaring stages of the log are all one stage per cycle.
// A stalled output fills a one-item skid register, then holds the whole pipeline.
// Reset clears the valid bits of every stage and of the output registers.
// ----------------------------------------------------------------------------
// ftle_from_neighbor_displacement: FTLE of one particle per cycle unless stalled
// Flow-map gradient by division, Cauchy-Green tensor, largest eigenvalue, ln.
// ----------------------------------------------------------------------------
`default_nettype none

module ftle_from_neighbor_displacement (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ftle_in_if.sink      in_ch,
    ftle_out_if.source   out_ch
);

    function automatic ftle_pkg::sm_t unpack(input logic [ftle_pkg::WORD_BITS-1:0] v);
        ftle_pkg::sm_t r;
        r.neg = v[ftle_pkg::WORD_BITS-1];
        r.mag = v[ftle_pkg::WORD_BITS-1] ? ftle_pkg::mag_t'(~v + 1'b1) : ftle_pkg::mag_t'(v);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    logic                  en;
    logic                  pipe_v;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    ftle_pkg::out_item_t   out_reg;
    ftle_pkg::out_item_t   skid_reg;
    ftle_pkg::out_item_t   pipe_item;
    ftle_pkg::ctl_t        ctl_next;
    ftle_pkg::ctl_t        ctl_reg [0:ftle_pkg::PIPE_DEPTH-1];

    assign en          = !skid_valid_reg;
    assign in_ch.ready = en;
    assign pipe_v      = ctl_reg[ftle_pkg::PIPE_DEPTH-1].valid;

    // ------------------------------------------------------------------
    // Entry: unpack operands, flag zero spacings
    // ------------------------------------------------------------------
    ftle_pkg::sm_t   u_n [0:ftle_pkg::LANES-1];
    ftle_pkg::sm_t   u_sx;
    ftle_pkg::sm_t   u_sy;
    ftle_pkg::side_t side_next;
    ftle_pkg::mag_t  nmag_reg [0:ftle_pkg::LANES-1];
    ftle_pkg::mag_t  dmag_reg [0:1];
    ftle_pkg::side_t side_reg [0:ftle_pkg::DIV_STEPS];

    always_comb
    begin
        u_n[ftle_pkg::LANE_A11] = unpack(in_ch.dx_lr);
        u_n[ftle_pkg::LANE_A21] = unpack(in_ch.dy_lr);
        u_n[ftle_pkg::LANE_A12] = unpack(in_ch.dx_tb);
        u_n[ftle_pkg::LANE_A22] = unpack(in_ch.dy_tb);
        u_sx = unpack(in_ch.span_x);
        u_sy = unpack(in_ch.span_y);

        side_next.lr   = in_ch.lr_valid;
        side_next.tb   = in_ch.tb_valid;
        side_next.dz_x = (u_sx.mag == '0);
        side_next.dz_y = (u_sy.mag == '0);
        for (int l = 0; l < ftle_pkg::LANES; l++)
        begin
            side_next.nz[l]  = (u_n[l].mag != '0);
            side_next.neg[l] = u_n[l].neg ^ ((l < 2) ? u_sx.neg : u_sy.neg);
        end

        ctl_next.valid  = in_ch.valid;
        ctl_next.in_dom = in_ch.inside_req;
        ctl_next.sat    = in_ch.inside_req &&
                          ((in_ch.lr_valid && side_next.dz_x) ||
                           (in_ch.tb_valid && side_next.dz_y));
    end

    // Advance the valid and flag line of every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ftle_pkg::PIPE_DEPTH; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_next;
            for (int i = 1; i < ftle_pkg::PIPE_DEPTH; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < ftle_pkg::LANES; l++)
            begin
                nmag_reg[l] <= u_n[l].mag;
            end
            dmag_reg[0] <= u_sx.mag;
            dmag_reg[1] <= u_sy.mag;
            side_reg[0] <= side_next;
            for (int i = 1; i <= ftle_pkg::DIV_STEPS; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider lanes: a11, a21 over span_x, a12, a22 over span_y
    // ------------------------------------------------------------------
    logic [ftle_pkg::NUM_BITS-1:0] quo [0:ftle_pkg::LANES-1];

    for (genvar l = 0; l < ftle_pkg::LANES; l++) begin : g_lane
        ftle_div u_div (
            .clk     (clk),
            .en      (en),
            .num_mag (nmag_reg[l]),
            .den_mag (dmag_reg[l >> 1]),
            .quo     (quo[l])
        );
    end

    // ------------------------------------------------------------------
    // Saturate quotients, zero missing columns
    // ------------------------------------------------------------------
    ftle_pkg::side_t side_a;
    ftle_pkg::sm_t   a_next [0:ftle_pkg::LANES-1];
    ftle_pkg::sm_t   a_reg  [0:ftle_pkg::LANES-1];

    always_comb
    begin
        logic           pv;
        logic           dz;
        ftle_pkg::mag_t lim;
        side_a = side_reg[ftle_pkg::DIV_STEPS];
        for (int l = 0; l < ftle_pkg::LANES; l++)
        begin
            pv  = (l < 2) ? side_a.lr : side_a.tb;
            dz  = (l < 2) ? side_a.dz_x : side_a.dz_y;
            lim = side_a.neg[l] ? ftle_pkg::NEG_LIM : ftle_pkg::POS_MAX;
            if (!pv)
                a_next[l].mag = '0;
            else if (dz)
                a_next[l].mag = side_a.nz[l] ? lim : '0;
            else if (quo[l] > ftle_pkg::NUM_BITS'(lim))
                a_next[l].mag = lim;
            else
                a_next[l].mag = quo[l][ftle_pkg::MAG_BITS-1:0];
            a_next[l].neg = side_a.neg[l] && (a_next[l].mag != '0);
        end
    end

    // ------------------------------------------------------------------
    // Products of the gradient entries
    // ------------------------------------------------------------------
    logic [ftle_pkg::PROD_BITS-1:0] prod_reg [0:5];
    logic [1:0]                     cn_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            prod_reg[0] <= ftle_pkg::PROD_BITS'(a_reg[ftle_pkg::LANE_A11].mag) *
                           ftle_pkg::PROD_BITS'(a_reg[ftle_pkg::LANE_A11].mag);
            prod_reg[1] <= ftle_pkg::PROD_BITS'(a_reg[ftle_pkg::LANE_A21].mag) *
                           ftle_pkg::PROD_BITS'(a_reg[ftle_pkg::LANE_A21].mag);
            prod_reg[2] <= ftle_pkg::PROD_BITS'(a_reg[ftle_pkg::LANE_A12].mag) *
                           ftle_pkg::PROD_BITS'(a_reg[ftle_pkg::LANE_A12].mag);
            prod_reg[3] <= ftle_pkg::PROD_BITS'(a_reg[ftle_pkg::LANE_A22].mag) *
                           ftle_pkg::PROD_BITS'(a_reg[ftle_pkg::LANE_A22].mag);
            prod_reg[4] <= ftle_pkg::PROD_BITS'(a_reg[ftle_pkg::LANE_A11].mag) *
                           ftle_pkg::PROD_BITS'(a_reg[ftle_pkg::LANE_A12].mag);
            prod_reg[5] <= ftle_pkg::PROD_BITS'(a_reg[ftle_pkg::LANE_A21].mag) *
                           ftle_pkg::PROD_BITS'(a_reg[ftle_pkg::LANE_A22].mag);
            cn_reg[0]   <= a_reg[ftle_pkg::LANE_A11].neg ^ a_reg[ftle_pkg::LANE_A12].neg;
            cn_reg[1]   <= a_reg[ftle_pkg::LANE_A21].neg ^ a_reg[ftle_pkg::LANE_A22].neg;
        end
    end

    // ------------------------------------------------------------------
    // Tensor entries p, r and cross term magnitude
    // ------------------------------------------------------------------
    logic [ftle_pkg::PROD_BITS:0]  p_sum;
    logic [ftle_pkg::PROD_BITS:0]  r_sum;
    logic [ftle_pkg::PROD_BITS:0]  q_sum;
    logic                          q_neg;
    logic [ftle_pkg::SH_BITS-1:0]  p_sh;
    logic [ftle_pkg::SH_BITS-1:0]  r_sh;
    logic [ftle_pkg::SH_BITS-1:0]  q_sh;
    ftle_pkg::mag_t                q_lim;
    logic [ftle_pkg::POS_BITS-1:0] p_next;
    logic [ftle_pkg::POS_BITS-1:0] r_next;
    ftle_pkg::mag_t                qm_next;
    logic [ftle_pkg::POS_BITS-1:0] p_reg;
    logic [ftle_pkg::POS_BITS-1:0] r_reg;
    ftle_pkg::mag_t                qm_reg;

    always_comb
    begin
        p_sum = {1'b0, prod_reg[0]} + {1'b0, prod_reg[1]};
        r_sum = {1'b0, prod_reg[2]} + {1'b0, prod_reg[3]};
        if (cn_reg[0] == cn_reg[1])
        begin
            q_sum = {1'b0, prod_reg[4]} + {1'b0, prod_reg[5]};
            q_neg = cn_reg[0];
        end
        else if (prod_reg[4] >= prod_reg[5])
        begin
            q_sum = {1'b0, prod_reg[4] - prod_reg[5]};
            q_neg = cn_reg[0];
        end
        else
        begin
            q_sum = {1'b0, prod_reg[5] - prod_reg[4]};
            q_neg = cn_reg[1];
        end
        p_sh  = p_sum[ftle_pkg::PROD_BITS:ftle_pkg::FRAC_BITS];
        r_sh  = r_sum[ftle_pkg::PROD_BITS:ftle_pkg::FRAC_BITS];
        q_sh  = q_sum[ftle_pkg::PROD_BITS:ftle_pkg::FRAC_BITS];
        q_lim = q_neg ? ftle_pkg::NEG_LIM : ftle_pkg::POS_MAX;
        // Cap the sums of squares at the largest positive word
        p_next  = (|p_sh[ftle_pkg::SH_BITS-1:ftle_pkg::POS_BITS]) ? '1 :
                  p_sh[ftle_pkg::POS_BITS-1:0];
        r_next  = (|r_sh[ftle_pkg::SH_BITS-1:ftle_pkg::POS_BITS]) ? '1 :
                  r_sh[ftle_pkg::POS_BITS-1:0];
        qm_next = (q_sh > ftle_pkg::SH_BITS'(q_lim)) ? q_lim :
                  q_sh[ftle_pkg::MAG_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // Half trace, difference, radicand
    // ------------------------------------------------------------------
    logic [ftle_pkg::POS_BITS:0]     pr_sum;
    logic [ftle_pkg::POS_BITS-1:0]   d_reg;
    logic [ftle_pkg::POS_BITS-1:0]   h_d_reg;
    ftle_pkg::mag_t                  qm_d_reg;
    logic [2*ftle_pkg::POS_BITS-1:0] dd_reg;
    logic [ftle_pkg::PROD_BITS-1:0]  qq_reg;
    logic [ftle_pkg::POS_BITS-1:0]   h_m_reg;
    logic [ftle_pkg::RAD_BITS-1:0]   y_reg;
    logic [ftle_pkg::POS_BITS-1:0]   h_y_reg;

    assign pr_sum = {1'b0, p_reg} + {1'b0, r_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= p_next;
            r_reg    <= r_next;
            qm_reg   <= qm_next;
            d_reg    <= (p_reg > r_reg) ? (p_reg - r_reg) : (r_reg - p_reg);
            h_d_reg  <= pr_sum[ftle_pkg::POS_BITS:1];
            qm_d_reg <= qm_reg;
            dd_reg   <= (2*ftle_pkg::POS_BITS)'(d_reg) * (2*ftle_pkg::POS_BITS)'(d_reg);
            qq_reg   <= ftle_pkg::PROD_BITS'(qm_d_reg) * ftle_pkg::PROD_BITS'(qm_d_reg);
            h_m_reg  <= h_d_reg;
            y_reg    <= ftle_pkg::RAD_BITS'(dd_reg >> 2) + ftle_pkg::RAD_BITS'(qq_reg);
            h_y_reg  <= h_m_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root, half trace delayed alongside
    // ------------------------------------------------------------------
    logic [ftle_pkg::ROOT_BITS-1:0] root;
    logic [ftle_pkg::POS_BITS-1:0]  hline_reg [0:ftle_pkg::ROOT_BITS-1];

    ftle_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (y_reg),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hline_reg[0] <= h_y_reg;
            for (int i = 1; i < ftle_pkg::ROOT_BITS; i++)
            begin
                hline_reg[i] <= hline_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Eigenvalue and normalization
    // ------------------------------------------------------------------
    logic [ftle_pkg::ROOT_BITS:0]    lam_sum;
    logic [ftle_pkg::POS_BITS-1:0]   lam_next;
    logic [ftle_pkg::POS_BITS-1:0]   lam_reg;
    logic                            live_l_reg;
    logic [ftle_pkg::K_BITS-1:0]     k_next;
    logic [ftle_pkg::K_BITS-1:0]     nk_reg;
    logic [ftle_pkg::LOG_M_BITS-1:0] nm_reg;
    logic                            nlive_reg;

    assign lam_sum  = (ftle_pkg::ROOT_BITS + 1)'(hline_reg[ftle_pkg::ROOT_BITS-1]) +
                      (ftle_pkg::ROOT_BITS + 1)'(root);
    assign lam_next = (|lam_sum[ftle_pkg::ROOT_BITS:ftle_pkg::POS_BITS]) ? '1 :
                      lam_sum[ftle_pkg::POS_BITS-1:0];

    // Find the leading one
    always_comb
    begin
        k_next = '0;
        for (int i = 0; i < ftle_pkg::POS_BITS; i++)
        begin
            if (lam_reg[i])
            begin
                k_next = ftle_pkg::K_BITS'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lam_reg    <= lam_next;
            live_l_reg <= 64'(lam_next) > 64'(ftle_pkg::NEAR_ZERO_RAW);
            nk_reg     <= k_next;
            nm_reg     <= ftle_pkg::LOG_M_BITS'(lam_reg <<
                          (ftle_pkg::K_BITS'(ftle_pkg::LOG_FRAC) - k_next));
            nlive_reg  <= live_l_reg;
        end
    end

    // ------------------------------------------------------------------
    // log2 fraction: one square-and-compare per stage
    // ------------------------------------------------------------------
    logic [ftle_pkg::LOG_M_BITS-1:0] lm_reg    [0:ftle_pkg::LOG_FRAC-2];
    logic [ftle_pkg::K_BITS-1:0]     lk_reg    [0:ftle_pkg::LOG_FRAC-1];
    logic [ftle_pkg::LOG_FRAC-1:0]   lf_reg    [0:ftle_pkg::LOG_FRAC-1];
    logic                            llive_reg [0:ftle_pkg::LOG_FRAC-1];

    for (genvar j = 0; j < ftle_pkg::LOG_FRAC; j++) begin : g_log
        logic [ftle_pkg::LOG_M_BITS-1:0]   m_prev;
        logic [ftle_pkg::K_BITS-1:0]       k_prev;
        logic [ftle_pkg::LOG_FRAC-1:0]     f_prev;
        logic                              live_prev;
        logic [2*ftle_pkg::LOG_M_BITS-1:0] sq;
        logic [ftle_pkg::LOG_FRAC-1:0]     f_next;

        if (j == 0) begin : g_head
            assign m_prev    = nm_reg;
            assign k_prev    = nk_reg;
            assign f_prev    = '0;
            assign live_prev = nlive_reg;
        end else begin : g_body
            assign m_prev    = lm_reg[j-1];
            assign k_prev    = lk_reg[j-1];
            assign f_prev    = lf_reg[j-1];
            assign live_prev = llive_reg[j-1];
        end

        assign sq = (2*ftle_pkg::LOG_M_BITS)'(m_prev) * (2*ftle_pkg::LOG_M_BITS)'(m_prev);

        always_comb
        begin
            f_next = f_prev;
            f_next[ftle_pkg::LOG_FRAC-1-j] = sq[2*ftle_pkg::LOG_M_BITS-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lk_reg[j]    <= k_prev;
                lf_reg[j]    <= f_next;
                llive_reg[j] <= live_prev;
            end
        end

        // Renormalize the square back into [1,2)
        if (j < ftle_pkg::LOG_FRAC - 1) begin : g_m
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    lm_reg[j] <= sq[2*ftle_pkg::LOG_M_BITS-1] ?
                        sq[2*ftle_pkg::LOG_M_BITS-1 -: ftle_pkg::LOG_M_BITS] :
                        sq[2*ftle_pkg::LOG_M_BITS-2 -: ftle_pkg::LOG_M_BITS];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Scale by ln 2, round to the word
    // ------------------------------------------------------------------
    logic [ftle_pkg::K_BITS:0]          k_exp;
    logic signed [ftle_pkg::LG_BITS-1:0] lg;
    logic signed [ftle_pkg::V_BITS-1:0]  v_reg;
    logic                                v_live_reg;
    logic signed [ftle_pkg::V_BITS-1:0]  t_sum;
    logic signed [ftle_pkg::V_BITS-1:0]  t_shift;
    ftle_pkg::ctl_t                      ctl_v;

    assign k_exp = {1'b0, lk_reg[ftle_pkg::LOG_FRAC-1]} -
                   (ftle_pkg::K_BITS + 1)'(ftle_pkg::FRAC_BITS);
    assign lg    = {k_exp, lf_reg[ftle_pkg::LOG_FRAC-1]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg      <= lg * $signed(ftle_pkg::LN2_BITS'(ftle_pkg::LN2_Q26));
            v_live_reg <= llive_reg[ftle_pkg::LOG_FRAC-1];
        end
    end

    assign ctl_v   = ctl_reg[ftle_pkg::PIPE_DEPTH-1];
    assign t_sum   = v_reg + ftle_pkg::ROUND_HALF;
    assign t_shift = t_sum >>> ftle_pkg::LN_SHIFT;

    always_comb
    begin
        pipe_item.computed   = ctl_v.in_dom && v_live_reg;
        pipe_item.saturated  = ctl_v.sat;
        pipe_item.ftle_value = pipe_item.computed ?
                               t_shift[ftle_pkg::WORD_BITS-1:0] : '0;
    end

    // ------------------------------------------------------------------
    // Output register and skid
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ch.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= pipe_v;
            end
        end
        else if (pipe_v && en)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ch.ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : pipe_item;
        end
        else if (en)
        begin
            skid_reg <= pipe_item;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.ftle_value = out_reg.ftle_value;
    assign out_ch.computed   = out_reg.computed;
    assign out_ch.saturated  = out_reg.saturated;

`ifndef SYNTHESIS
    // Skid only ever holds an item behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while output is empty");

    // An item leaving the pipeline into a held output lands in the skid
    a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_v && en && out_valid_reg && !out_ch.ready) |=> skid_valid_reg)
        else $error("item leaving the pipeline was dropped");

    // No log taken means a zero value
    a_zero_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.computed) |-> (out_reg.ftle_value == '0))
        else $error("nonzero value without a computed log");

    // A particle outside the domain never raises the saturation or computed flag
    a_outside_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_v && !ctl_v.in_dom) |-> (!ctl_v.sat && !pipe_item.computed))
        else $error("outside particle carries flags");
`endif

endmodule

`default_nettype wire

### sim/ftle_from_neighbor_displacement_tb.sv
// ----------------------------------------------------------------------------
// ftle_from_neighbor_displacement_tb: self-checking bench for the FTLE block
// Drives particles over the input channel, predicts each result in fixed
// point (division, Cauchy-Green tensor, eigenvalue, log) and compares every
// result item field by field, under random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module ftle_from_neighbor_displacement_tb;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int DRAIN_CYCLES    = 130;
    localparam int RANDOM_ITEMS    = 800;

    typedef logic [ftle_pkg::WORD_BITS-1:0] word_t;

    typedef struct {
        logic  in_dom;
        logic  lr;
        logic  tb;
        word_t dx_lr;
        word_t dy_lr;
        word_t span_x;
        word_t dx_tb;
        word_t dy_tb;
        word_t span_y;
    } particle_t;

    typedef struct {
        logic        neg;
        logic [63:0] mag;
    } smag_t;

    logic clk;
    logic rst_n;
    logic quiet;
    int   mismatches;
    int   results_seen;
    int   items_sent;
    int   log_taken;
    int   sat_seen;
    int   idle_cycles;

    ftle_pkg::out_item_t expected_results[$];

    ftle_in_if  in_ch ();
    ftle_out_if out_ch ();

    ftle_from_neighbor_displacement uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------------
    function automatic logic [63:0] limit_of(input logic neg);
        return neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    endfunction

    function automatic smag_t to_smag(input word_t v);
        smag_t r;
        r.neg = v[ftle_pkg::WORD_BITS-1];
        r.mag = r.neg ? 64'(word_t'(-v)) : 64'(v);
        if (v == 0)
            r.neg = 1'b0;
        if (r.neg && r.mag == 0)
            r.mag = 64'h8000_0000;
        return r;
    endfunction

    function automatic smag_t gradient_quotient(input smag_t n, input smag_t d,
                                                inout logic sat);
        smag_t       r;
        logic [63:0] q;
        if (d.mag == 0)
        begin
            sat   = 1'b1;
            r.neg = n.neg;
            r.mag = (n.mag != 0) ? limit_of(n.neg) : 64'd0;
            return r;
        end
        r.neg = n.neg != d.neg;
        q     = (n.mag << ftle_pkg::FRAC_BITS) / d.mag;
        r.mag = (q > limit_of(r.neg)) ? limit_of(r.neg) : q;
        if (r.mag == 0)
            r.neg = 1'b0;
        return r;
    endfunction

    // Signed sum of two products, shifted down and saturated
    function automatic smag_t tensor_term(input smag_t a, input smag_t b,
                                          input smag_t c, input smag_t d);
        smag_t       r;
        logic [64:0] t1;
        logic [64:0] t2;
        logic [64:0] s;
        logic        n1;
        logic        n2;
        t1 = a.mag * b.mag;
        t2 = c.mag * d.mag;
        n1 = a.neg != b.neg;
        n2 = c.neg != d.neg;
        if (n1 == n2)
        begin
            s     = t1 + t2;
            r.neg = n1;
        end
        else if (t1 >= t2)
        begin
            s     = t1 - t2;
            r.neg = n1;
        end
        else
        begin
            s     = t2 - t1;
            r.neg = n2;
        end
        s     = s >> ftle_pkg::FRAC_BITS;
        r.mag = (s > limit_of(r.neg)) ? limit_of(r.neg) : s[63:0];
        if (r.mag == 0)
            r.neg = 1'b0;
        return r;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] cand;
        root = 0;
        for (int i = 31; i >= 0; i--)
        begin
            cand = root | (64'd1 << i);
            if (cand * cand <= x)
                root = cand;
        end
        return root;
    endfunction

    function automatic word_t ln_fixed(input logic [63:0] raw);
        int                 k;
        logic [63:0]        m;
        logic [63:0]        frac;
        logic signed [63:0] lg;
        logic signed [63:0] t;
        logic [63:0]        a;
        logic [63:0]        mag;
        logic               neg;
        k = 63;
        while (k > 0 && raw[k] == 1'b0)
            k--;
        m    = (k >= ftle_pkg::LOG_FRAC) ? (raw >> (k - ftle_pkg::LOG_FRAC)) :
                                           (raw << (ftle_pkg::LOG_FRAC - k));
        frac = 0;
        for (int i = 1; i <= ftle_pkg::LOG_FRAC; i++)
        begin
            m = (m * m) >> ftle_pkg::LOG_FRAC;
            if (m >= (64'd2 << ftle_pkg::LOG_FRAC))
            begin
                m    = m >> 1;
                frac = frac | (64'd1 << (ftle_pkg::LOG_FRAC - i));
            end
        end
        lg = (64'(k) - ftle_pkg::FRAC_BITS) * (64'sd1 << ftle_pkg::LOG_FRAC) + $signed(frac);
        t  = lg * 64'sd46516320 + (64'sd1 << (ftle_pkg::LN_SHIFT - 1));
        if (t >= 0)
        begin
            neg = 1'b0;
            mag = t >>> ftle_pkg::LN_SHIFT;
        end
        else
        begin
            neg = 1'b1;
            a   = -t;
            mag = (a + ((64'd1 << ftle_pkg::LN_SHIFT) - 1)) >> ftle_pkg::LN_SHIFT;
        end
        if (mag > limit_of(neg))
            mag = limit_of(neg);
        return neg ? word_t'(-mag) : word_t'(mag);
    endfunction

    function automatic ftle_pkg::out_item_t predict_ftle(input particle_t pt);
        ftle_pkg::out_item_t res;
        smag_t       zero;
        smag_t       a11;
        smag_t       a21;
        smag_t       a12;
        smag_t       a22;
        smag_t       qv;
        logic        sat;
        logic [63:0] p;
        logic [63:0] r;
        logic [63:0] d;
        logic [63:0] y;
        logic [63:0] lam;
        zero = '{1'b0, 64'd0};
        a11  = zero;
        a21  = zero;
        a12  = zero;
        a22  = zero;
        sat  = 1'b0;
        res  = '0;
        if (!pt.in_dom)
            return res;
        if (pt.lr)
        begin
            a11 = gradient_quotient(to_smag(pt.dx_lr), to_smag(pt.span_x), sat);
            a21 = gradient_quotient(to_smag(pt.dy_lr), to_smag(pt.span_x), sat);
        end
        if (pt.tb)
        begin
            a12 = gradient_quotient(to_smag(pt.dx_tb), to_smag(pt.span_y), sat);
            a22 = gradient_quotient(to_smag(pt.dy_tb), to_smag(pt.span_y), sat);
        end
        p   = tensor_term(a11, a11, a21, a21).mag;
        r   = tensor_term(a12, a12, a22, a22).mag;
        qv  = tensor_term(a11, a12, a21, a22);
        d   = (p > r) ? p - r : r - p;
        y   = ((d * d) >> 2) + qv.mag * qv.mag;
        lam = ((p + r) >> 1) + floor_sqrt(y);
        if (lam > 64'h7FFF_FFFF)
            lam = 64'h7FFF_FFFF;
        res.saturated = sat;
        if (lam > ftle_pkg::NEAR_ZERO_RAW)
        begin
            res.ftle_value = ln_fixed(lam);
            res.computed   = 1'b1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic send_particle(input particle_t pt);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.inside_req <= pt.in_dom;
        in_ch.lr_valid   <= pt.lr;
        in_ch.tb_valid   <= pt.tb;
        in_ch.dx_lr      <= pt.dx_lr;
        in_ch.dy_lr      <= pt.dy_lr;
        in_ch.span_x     <= pt.span_x;
        in_ch.dx_tb      <= pt.dx_tb;
        in_ch.dy_tb      <= pt.dy_tb;
        in_ch.span_y     <= pt.span_y;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_results = {expected_results, predict_ftle(pt)};
        items_sent++;
    endtask

    function automatic particle_t make_particle(input logic in_dom, input logic lr,
                                                input logic tb, input word_t dxl,
                                                input word_t dyl, input word_t sx,
                                                input word_t dxt, input word_t dyt,
                                                input word_t sy);
        particle_t pt;
        pt = '{in_dom, lr, tb, dxl, dyl, sx, dxt, dyt, sy};
        return pt;
    endfunction

    // Displacement near a plausible stretch: a few units, random sign
    function automatic word_t small_fixed();
        word_t v;
        v = word_t'($urandom_range(0, 32'h0008_0000));
        return $urandom_range(0, 1) ? word_t'(-v) : v;
    endfunction

    function automatic word_t any_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_outside();
        send_particle(make_particle(0, 1, 1, 32'h0001_0000, 32'h0, 32'h0001_0000,
                                    32'h0, 32'h0001_0000, 32'h0001_0000));
        send_particle(make_particle(0, 1, 1, 32'h1234, 32'h5678, 32'h0,
                                    32'h1, 32'h2, 32'h0));
    endtask

    task automatic test_pairs();
        // identity gradient, single pairs, no pairs
        send_particle(make_particle(1, 1, 1, 32'h0001_0000, 32'h0, 32'h0001_0000,
                                    32'h0, 32'h0001_0000, 32'h0001_0000));
        send_particle(make_particle(1, 1, 0, 32'h0003_0000, 32'hFFFF_0000,
                                    32'h0001_0000, 32'hFFFF_FFFF, 32'h7, 32'h0));
        send_particle(make_particle(1, 0, 1, 32'h0, 32'h0, 32'h0,
                                    32'h0000_8000, 32'hFFFE_0000, 32'h0002_0000));
        send_particle(make_particle(1, 0, 0, 32'hFFFF_FFFF, 32'h1, 32'h0,
                                    32'h1, 32'h1, 32'h0));
        // eigenvalue collapses to zero
        send_particle(make_particle(1, 1, 1, 32'h0, 32'h0, 32'h0001_0000,
                                    32'h0, 32'h0, 32'h0001_0000));
        send_particle(make_particle(1, 1, 1, 32'h1, 32'h0, 32'h7FFF_FFFF,
                                    32'h0, 32'h1, 32'h7FFF_FFFF));
    endtask

    task automatic test_zero_spacing();
        send_particle(make_particle(1, 1, 0, 32'h0000_1000, 32'h0, 32'h0,
                                    32'h0, 32'h0, 32'h0001_0000));
        send_particle(make_particle(1, 1, 0, 32'hFFFF_F000, 32'h1, 32'h0,
                                    32'h0, 32'h0, 32'h0));
        send_particle(make_particle(1, 0, 1, 32'h0, 32'h0, 32'h0001_0000,
                                    32'h0, 32'h0, 32'h0));
        send_particle(make_particle(1, 1, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    endtask

    task automatic test_extremes();
        // silent quotient overflow and word limits everywhere
        send_particle(make_particle(1, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
                                    32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_particle(make_particle(1, 1, 1, 32'h8000_0000, 32'h8000_0000,
                                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    32'h8000_0000));
        send_particle(make_particle(1, 1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF));
        send_particle(make_particle(1, 1, 1, 32'h1, 32'h1, 32'h7FFF_FFFF,
                                    32'hFFFF_FFFF, 32'h1, 32'h8000_0000));
        send_particle(make_particle(1, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF));
    endtask

    task automatic test_random();
        particle_t pt;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - 150)
                quiet = 1'b1;
            pt.in_dom = ($urandom_range(0, 9) != 0);
            pt.lr     = ($urandom_range(0, 7) != 0);
            pt.tb     = ($urandom_range(0, 7) != 0);
            if ($urandom_range(0, 3) != 0)
            begin
                // plausible grid: spacing of up to two units, sometimes zero
                pt.dx_lr  = small_fixed();
                pt.dy_lr  = small_fixed();
                pt.dx_tb  = small_fixed();
                pt.dy_tb  = small_fixed();
                pt.span_x = word_t'($urandom_range(1, 32'h0002_0000));
                pt.span_y = word_t'($urandom_range(1, 32'h0002_0000));
                if ($urandom_range(0, 31) == 0)
                    pt.span_x = 0;
                if ($urandom_range(0, 31) == 0)
                    pt.span_y = 0;
            end
            else
            begin
                pt.dx_lr  = any_word();
                pt.dy_lr  = any_word();
                pt.span_x = any_word();
                pt.dx_tb  = any_word();
                pt.dy_tb  = any_word();
                pt.span_y = any_word();
            end
            send_particle(pt);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, then compare against the oldest expectation
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            idle_cycles  <= 0;
        end
        else if (idle_cycles > 0)
        begin
            out_ch.ready <= 1'b0;
            idle_cycles  <= idle_cycles - 1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            out_ch.ready <= 1'b0;
            idle_cycles  <= $urandom_range(0, 4);
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        ftle_pkg::out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: ftle=%h computed=%b saturated=%b",
                             out_ch.ftle_value, out_ch.computed, out_ch.saturated);
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_ch.computed)
                    log_taken++;
                if (out_ch.saturated)
                    sat_seen++;
                if (out_ch.ftle_value !== want.ftle_value
                    || out_ch.computed !== want.computed
                    || out_ch.saturated !== want.saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d mismatch: ftle %h/%h computed %b/%b sat %b/%b",
                                 results_seen, want.ftle_value, out_ch.ftle_value,
                                 want.computed, out_ch.computed,
                                 want.saturated, out_ch.saturated);
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        int stuck;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stuck = 0;
        else
            stuck++;
        if (stuck >= WATCHDOG_CYCLES)
        begin
            $display("watchdog expired with %0d results outstanding",
                     expected_results.size());
            $display("ftle_from_neighbor_displacement_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        quiet            = 1'b0;
        mismatches       = 0;
        results_seen     = 0;
        items_sent       = 0;
        log_taken        = 0;
        sat_seen         = 0;
        in_ch.valid      = 1'b0;
        in_ch.inside_req = 1'b0;
        in_ch.lr_valid   = 1'b0;
        in_ch.tb_valid   = 1'b0;
        in_ch.dx_lr      = '0;
        in_ch.dy_lr      = '0;
        in_ch.span_x     = '0;
        in_ch.dx_tb      = '0;
        in_ch.dy_tb      = '0;
        in_ch.span_y     = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_outside();
        test_pairs();
        test_zero_spacing();
        test_extremes();
        test_random();

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d particles, %0d results: %0d with log taken, %0d saturated",
                 items_sent, results_seen, log_taken, sat_seen);
        if (mismatches == 0)
            $display("ftle_from_neighbor_displacement_tb: done, clean");
        else
        begin
            $display("%0d mismatching results", mismatches);
            $display("ftle_from_neighbor_displacement_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

### ftle_from_neighbor_displacement.f
design/ftle_pkg.sv
design/ftle_if.sv
design/ftle_div.sv
design/ftle_sqrt.sv
design/ftle_from_neighbor_displacement.sv
sim/ftle_from_neighbor_displacement_tb.sv
